>>> rtl/bdi_pkg.sv
`default_nettype none

package bdi_pkg;

  // Store size and derived widths
  localparam int unsigned PACKET_BYTES = 4096;
  localparam int unsigned ADDR_W = $clog2(PACKET_BYTES);
  localparam int unsigned CNT_W = $clog2(PACKET_BYTES + 1);

  // Register and product widths
  localparam int unsigned ROWS_W = 8;
  localparam int unsigned COLS_W = 16;
  localparam int unsigned CHUNK_W = 16;
  localparam int unsigned HW_W = ROWS_W + COLS_W;
  localparam int unsigned PROD_W = HW_W + CHUNK_W;
  localparam int unsigned SUM_W = PROD_W + 1;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_CHUNK = 2'd2;

  // Input item kinds
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic [ROWS_W-1:0]  rows;
    logic [COLS_W-1:0]  cols;
    logic [CHUNK_W-1:0] chunk_bytes;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       last;
    logic       empty_res;
  } res_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] bytes_loaded;
    logic [CNT_W-1:0] bytes_read;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/bdi_ram.sv
`default_nettype none

module bdi_ram
  import bdi_pkg::*;
(
  input  wire logic     clk_i,
  input  wire ram_req_t req_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [PACKET_BYTES];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/bdi_ctrl.sv
`default_nettype none

module bdi_ctrl
  import bdi_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       in_valid_i,
  input  wire logic       in_action_i,
  input  wire logic [7:0] in_data_i,
  output logic            in_ready_o,
  input  wire logic       out_free_i,
  output ram_req_t        ram_req_o,
  input  wire logic [7:0] ram_rdata_i,
  output res_t            res_o,
  output stat_t           stat_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL1 = 5'b00010,
    ST_MUL2 = 5'b00100,
    ST_ADDR = 5'b01000,
    ST_DATA = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]   loaded_q, loaded_d;
  logic [CNT_W-1:0]   read_q, read_d;
  logic [CNT_W-1:0]   base_q, base_d;
  logic [CHUNK_W-1:0] off_q, off_d;
  logic [ROWS_W-1:0]  row_q, row_d;
  logic [COLS_W-1:0]  col_q, col_d;
  logic               in_range_q, in_range_d;
  logic               last_q, last_d;
  logic               empty_q, empty_d;

  // Product pipeline, no reset needed
  logic [HW_W-1:0]   hw_q, hw_d;
  logic [HW_W-1:0]   rw_q, rw_d;
  logic [PROD_W-1:0] s_q, s_d;
  logic [PROD_W-1:0] t_q, t_d;

  logic [ROWS_W-1:0]  h;
  logic [COLS_W-1:0]  w;
  logic [CHUNK_W-1:0] b;

  logic               accept;
  logic               sb_hit;
  logic [CNT_W-1:0]   span;
  logic [SUM_W-1:0]   sb_addr;
  logic [SUM_W-1:0]   rd_addr;
  logic [CHUNK_W:0]   off_inc;
  logic [ROWS_W:0]    row_inc;
  logic [COLS_W:0]    col_inc;
  logic [CNT_W-1:0]   read_inc;

  // A zero register acts as one
  assign h = (cfg_i.rows == '0) ? ROWS_W'(1) : cfg_i.rows;
  assign w = (cfg_i.cols == '0) ? COLS_W'(1) : cfg_i.cols;
  assign b = (cfg_i.chunk_bytes == '0) ? CHUNK_W'(1) : cfg_i.chunk_bytes;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept = in_valid_i && in_ready_o;

  // Superblock test and address from the nested counters
  assign span = loaded_q - base_q;
  assign sb_hit = (loaded_q >= base_q) && (PROD_W'(span) >= s_q);
  assign sb_addr = SUM_W'(base_q) + SUM_W'(t_q) + SUM_W'(off_q);
  assign rd_addr = sb_hit ? sb_addr : SUM_W'(read_q);

  assign off_inc = {1'b0, off_q} + (CHUNK_W + 1)'(1);
  assign row_inc = {1'b0, row_q} + (ROWS_W + 1)'(1);
  assign col_inc = {1'b0, col_q} + (COLS_W + 1)'(1);
  assign read_inc = read_q + CNT_W'(1);

  always_comb begin
    state_d    = state_q;
    loaded_d   = loaded_q;
    read_d     = read_q;
    base_d     = base_q;
    off_d      = off_q;
    row_d      = row_q;
    col_d      = col_q;
    in_range_d = in_range_q;
    last_d     = last_q;
    empty_d    = empty_q;
    hw_d       = hw_q;
    rw_d       = rw_q;
    s_d        = s_q;
    t_d        = t_q;
    ram_req_o  = '0;
    res_o      = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_action_i == ACT_LOAD) begin
            // Append unless the store is full
            if (loaded_q < CNT_W'(PACKET_BYTES)) begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = loaded_q[ADDR_W-1:0];
              ram_req_o.wdata = in_data_i;
              loaded_d        = loaded_q + CNT_W'(1);
            end
          end else if (read_q >= loaded_q) begin
            // Nothing pending: flag empty, counters unchanged
            empty_d    = 1'b1;
            in_range_d = 1'b0;
            last_d     = 1'b0;
            state_d    = ST_DATA;
          end else begin
            empty_d = 1'b0;
            state_d = ST_MUL1;
          end
        end
      end

      ST_MUL1: begin
        hw_d    = HW_W'(h) * HW_W'(w);
        rw_d    = HW_W'(row_q) * HW_W'(w) + HW_W'(col_q);
        state_d = ST_MUL2;
      end

      ST_MUL2: begin
        s_d     = PROD_W'(hw_q) * PROD_W'(b);
        t_d     = PROD_W'(rw_q) * PROD_W'(b);
        state_d = ST_ADDR;
      end

      ST_ADDR: begin
        // Issue the store read and advance the counters
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = rd_addr[ADDR_W-1:0];
        in_range_d      = (rd_addr < SUM_W'(loaded_q));
        if (sb_hit) begin
          if (off_inc >= (CHUNK_W + 1)'(b)) begin
            off_d = '0;
            if (row_inc >= (ROWS_W + 1)'(h)) begin
              row_d = '0;
              if (col_inc >= (COLS_W + 1)'(w)) begin
                col_d  = '0;
                base_d = base_q + s_q[CNT_W-1:0];
              end else begin
                col_d = col_inc[COLS_W-1:0];
              end
            end else begin
              row_d = row_inc[ROWS_W-1:0];
            end
          end else begin
            off_d = off_inc[CHUNK_W-1:0];
          end
        end else begin
          off_d  = '0;
          row_d  = '0;
          col_d  = '0;
          base_d = read_inc;
        end
        read_d = read_inc;
        last_d = (read_inc >= loaded_q);
        // Final byte empties the store
        if (read_inc >= loaded_q) begin
          loaded_d = '0;
          read_d   = '0;
          base_d   = '0;
          off_d    = '0;
          row_d    = '0;
          col_d    = '0;
        end
        state_d = ST_DATA;
      end

      ST_DATA: begin
        // Hold until the output register has room
        if (out_free_i) begin
          res_o.valid     = 1'b1;
          res_o.out_byte  = in_range_q ? ram_rdata_i : 8'd0;
          res_o.last      = last_q;
          res_o.empty_res = empty_q;
          state_d         = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      loaded_q   <= '0;
      read_q     <= '0;
      base_q     <= '0;
      off_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      in_range_q <= 1'b0;
      last_q     <= 1'b0;
      empty_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      loaded_q   <= loaded_d;
      read_q     <= read_d;
      base_q     <= base_d;
      off_q      <= off_d;
      row_q      <= row_d;
      col_q      <= col_d;
      in_range_q <= in_range_d;
      last_q     <= last_d;
      empty_q    <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hw_q <= hw_d;
    rw_q <= rw_d;
    s_q  <= s_d;
    t_q  <= t_d;
  end

  assign stat_o.busy         = (state_q != ST_IDLE);
  assign stat_o.bytes_loaded = loaded_q;
  assign stat_o.bytes_read   = read_q;

endmodule

`default_nettype wire

>>> rtl/block_deinterleaver_unit.sv
`default_nettype none

// Channel     | Direction | Handshake               | Payload
// s_axis      | in        | s_axis_tvalid/tready    | tdata: data_byte; tuser: action
// m_axis      | out       | m_axis_tvalid/tready    | tdata: out_byte; tlast: last;
//             |           |                         | tuser: empty_res
// cfg         | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A load is taken in the idle state without leaving it; a read passes through two multiply
// stages, the store read and the result hand-off before the idle state takes the next
// transaction; a read of an empty store goes straight to the result hand-off.
// Reset clears the pointers and counters; the store needs no clearing pass.
// Configuration writes wait until the sequencer is idle and no input is offered.
// A result waits in the output register; a read stalls in its last cycle until free.

module block_deinterleaver_unit
  import bdi_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic [0:0]   s_axis_tuser,   // [0] action
  // Output stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] out_byte
  output logic              m_axis_tlast,
  output logic [0:0]        m_axis_tuser,   // [0] empty_res
  // Configuration writes
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [15:0]  cfg_data_i
);

  cfg_t     cfg_q;
  ram_req_t ram_req;
  logic [7:0] ram_rdata;
  res_t     res;
  stat_t    stat;
  logic     out_free;

  logic       m_valid_q;
  logic [7:0] m_data_q;
  logic       m_last_q;
  logic       m_empty_q;

  // Register file, written only while idle
  assign cfg_ready_o = !stat.busy && !s_axis_tvalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows        <= ROWS_W'(1);
      cfg_q.cols        <= COLS_W'(1);
      cfg_q.chunk_bytes <= CHUNK_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROWS:  cfg_q.rows        <= cfg_data_i[ROWS_W-1:0];
        REG_COLS:  cfg_q.cols        <= cfg_data_i[COLS_W-1:0];
        REG_CHUNK: cfg_q.chunk_bytes <= cfg_data_i[CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  bdi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser[0]),
    .in_data_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .out_free_i  (out_free),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_o       (res),
    .stat_o      (stat)
  );

  bdi_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Output register
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res.valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      m_data_q  <= res.out_byte;
      m_last_q  <= res.last;
      m_empty_q <= res.empty_res;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tlast    = m_last_q;
  assign m_axis_tuser[0] = m_empty_q;

  // An empty-store result carries zero data and no last flag
  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'd0 && !m_axis_tlast)
    else $error("empty result with data or last");

  // Read pointer stays behind the fill count unless the store is empty
  a_ptr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.bytes_read < stat.bytes_loaded) ||
    (stat.bytes_read == '0 && stat.bytes_loaded == '0))
    else $error("read pointer passed fill count");

  // Fill count never exceeds the store
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.bytes_loaded <= CNT_W'(PACKET_BYTES))
    else $error("fill count beyond store size");

  // An accepted read keeps the input side closed in the next cycle
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == ACT_READ
    |=> stat.busy && !s_axis_tready)
    else $error("read did not occupy the sequencer");

endmodule

`default_nettype wire
